// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the LED controller RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLPB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define MLPB_ASSERT_DEF(name, prop) `MLPB_ASSERT(name, clk_i, rst_ni, prop)
`else
`define MLPB_ASSERT(name, clk, rst_n, prop)
`define MLPB_ASSERT_DEF(name, prop)
`endif
`endif

// File: hw/rtl/mlpb_pkg.sv
// Types and constants of the multi LED PWM / blink controller.
// No dependencies.
package mlpb_pkg;

  localparam int unsigned LedCount = 4;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned RateW    = 16;
  localparam int unsigned CmdW     = 3;

  localparam logic [LedCount-1:0] MaskReset = 4'hF;

  typedef enum logic [CmdW-1:0] {
    CmdTick   = 3'd0,
    CmdOn     = 3'd1,
    CmdOff    = 3'd2,
    CmdToggle = 3'd3,
    CmdPwm    = 3'd4,
    CmdBlink  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModePwm    = 2'd1,
    ModeBlink  = 2'd2
  } chan_mode_e;

  typedef struct packed {
    logic [CmdW-1:0]  mode;
    logic [IdxW-1:0]  led_index;
    logic [RateW-1:0] rate_value;
  } cmd_word_t;

  // Per-channel control from the top level
  typedef struct packed {
    logic             fire;
    logic [CmdW-1:0]  cmd;
    logic             hit;
    logic [RateW-1:0] rate;
  } led_ctl_t;

endpackage

// File: hw/rtl/mlpb_cmd_if.sv
// Command / tick channel of the LED controller.
// Depends on mlpb_pkg.
interface mlpb_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mlpb_pkg::CmdW-1:0]    mode;
  logic [mlpb_pkg::IdxW-1:0]    led_index;
  logic [mlpb_pkg::RateW-1:0]   rate_value;

  modport source (output valid, mode, led_index, rate_value, input ready);
  modport sink   (input valid, mode, led_index, rate_value, output ready);
endinterface

// File: hw/rtl/mlpb_pins_if.sv
// Pin level result channel of the LED controller.
// Depends on mlpb_pkg.
interface mlpb_pins_if;
  logic                           valid;
  logic                           ready;
  logic [mlpb_pkg::LedCount-1:0]  pin_levels;

  modport source (output valid, pin_levels, input ready);
  modport sink   (input valid, pin_levels, output ready);
endinterface

// File: hw/rtl/mlpb_cfg_if.sv
// Configuration write channel (polarity mask) of the LED controller.
// Depends on mlpb_pkg.
interface mlpb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mlpb_pkg::LedCount-1:0]  active_high_mask;

  modport source (output valid, active_high_mask, input ready);
  modport sink   (input valid, active_high_mask, output ready);
endinterface

// File: hw/rtl/mlpb_channel.sv
// One LED channel: mode, rate, tick counter, PWM phase and pin bit.
// Depends on mlpb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mlpb_channel #(
  parameter int unsigned PWM_PERIOD = 20,
  parameter logic        PIN_RESET  = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlpb_pkg::led_ctl_t ctl_i,
  input  logic               mask_i,
  output logic               pin_o,
  output logic               pin_next_o
);
  import mlpb_pkg::*;

  localparam logic [RateW:0] PeriodW = (RateW+1)'(PWM_PERIOD);

  chan_mode_e       mode_q, mode_d;
  logic [RateW-1:0] rate_q, rate_d;
  logic [RateW-1:0] count_q, count_d;
  logic             phase_q, phase_d;
  logic             pin_q, pin_d;
  logic [RateW-1:0] count_dec;
  logic             duty_full;

  assign count_dec = count_q - RateW'(1);
  assign duty_full = {1'b0, rate_q} >= PeriodW;

  always_comb begin
    mode_d  = mode_q;
    rate_d  = rate_q;
    count_d = count_q;
    phase_d = phase_q;
    pin_d   = pin_q;
    if (ctl_i.fire) begin
      if (cmd_e'(ctl_i.cmd) == CmdTick) begin
        case (mode_q)
          ModePwm: begin
            if (rate_q == '0) begin
              pin_d = ~mask_i;
            end else if (duty_full) begin
              pin_d = mask_i;
            end else begin
              count_d = count_dec;
              if (count_dec == '0) begin
                if (phase_q) begin
                  pin_d   = ~mask_i;
                  count_d = RateW'(PeriodW - {1'b0, rate_q});
                  phase_d = 1'b0;
                end else begin
                  pin_d   = mask_i;
                  count_d = rate_q;
                  phase_d = 1'b1;
                end
              end
            end
          end
          ModeBlink: begin
            count_d = count_dec;
            if (count_dec == '0) begin
              pin_d   = ~pin_q;
              count_d = rate_q;
            end
          end
          default: ;
        endcase
      end else if (ctl_i.hit) begin
        case (cmd_e'(ctl_i.cmd))
          CmdOn: begin
            pin_d  = mask_i;
            mode_d = ModeNormal;
          end
          CmdOff: begin
            pin_d  = ~mask_i;
            mode_d = ModeNormal;
          end
          CmdToggle: pin_d = ~pin_q;
          CmdPwm: begin
            mode_d  = ModePwm;
            rate_d  = ctl_i.rate;
            count_d = ctl_i.rate;
            phase_d = 1'b1;
          end
          CmdBlink: begin
            mode_d  = ModeBlink;
            rate_d  = ctl_i.rate;
            count_d = ctl_i.rate;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      rate_q  <= '0;
      count_q <= '0;
      phase_q <= 1'b1;
      pin_q   <= PIN_RESET;
    end else begin
      mode_q  <= mode_d;
      rate_q  <= rate_d;
      count_q <= count_d;
      phase_q <= phase_d;
      pin_q   <= pin_d;
    end
  end

  assign pin_o      = pin_q;
  assign pin_next_o = pin_d;

  `MLPB_ASSERT_DEF(a_onoff_normal, ctl_i.fire && ctl_i.hit && (ctl_i.cmd == CmdOn || ctl_i.cmd == CmdOff) |=> mode_q == ModeNormal)
  `MLPB_ASSERT_DEF(a_pwm_load, ctl_i.fire && ctl_i.hit && ctl_i.cmd == CmdPwm |=> mode_q == ModePwm && phase_q && count_q == $past(ctl_i.rate))
  `MLPB_ASSERT_DEF(a_blink_wrap, ctl_i.fire && ctl_i.cmd == CmdTick && mode_q == ModeBlink && count_q == RateW'(1) |=> pin_q != $past(pin_q) && count_q == rate_q)
endmodule

// File: hw/rtl/multi_led_pwm_blink_controller_top.sv
// Multi LED controller: normal, PWM and blink modes on four pins.
// Depends on mlpb_pkg, the channel interfaces, mlpb_channel and assert_macros.svh.
// Path: input reg holds the command word; result reg takes its result when the output is free.
// Throughput: one word per cycle while the result side is ready; all channels update in parallel in one pass.
// Reset: every channel in normal mode, polarity mask all ones, all LEDs off.
`include "assert_macros.svh"
module multi_led_pwm_blink_controller_top #(
  parameter int unsigned PWM_PERIOD = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  mlpb_cmd_if.sink    cmd_i,
  mlpb_cfg_if.sink    cfg_i,
  mlpb_pins_if.source pins_o
);
  import mlpb_pkg::*;

  logic                in_valid_q, in_valid_d;
  cmd_word_t           item_q;
  logic                out_valid_q, out_valid_d;
  logic [LedCount-1:0] pins_q;
  logic [LedCount-1:0] mask_q;
  logic [LedCount-1:0] pin_cur;
  logic [LedCount-1:0] pin_next;
  logic                out_free;
  logic                fire;
  logic                cmd_take;

  assign out_free    = !out_valid_q || pins_o.ready;
  assign fire        = in_valid_q && out_free;
  assign cmd_i.ready = !in_valid_q || fire;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  assign in_valid_d  = cmd_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (pins_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= MaskReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mask_q <= cfg_i.active_high_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      item_q.mode       <= cmd_i.mode;
      item_q.led_index  <= cmd_i.led_index;
      item_q.rate_value <= cmd_i.rate_value;
    end
    if (fire) begin
      pins_q <= pin_next;
    end
  end

  for (genvar i = 0; i < LedCount; i++) begin : g_chan
    led_ctl_t ctl;
    assign ctl.fire = fire;
    assign ctl.cmd  = item_q.mode;
    assign ctl.hit  = item_q.led_index == IdxW'(i);
    assign ctl.rate = item_q.rate_value;

    mlpb_channel #(
      .PWM_PERIOD (PWM_PERIOD),
      .PIN_RESET  (~MaskReset[i])
    ) u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .mask_i     (mask_q[i]),
      .pin_o      (pin_cur[i]),
      .pin_next_o (pin_next[i])
    );
  end

  assign pins_o.valid      = out_valid_q;
  assign pins_o.pin_levels = pins_q;

  `MLPB_ASSERT_DEF(a_fire_out_valid, fire |=> out_valid_q)
  `MLPB_ASSERT_DEF(a_out_matches_pins, fire |=> pins_q == pin_cur)
  `MLPB_ASSERT_DEF(a_item_kept, in_valid_q && !fire |=> in_valid_q && $stable(item_q))
endmodule
